>>> rtl/core/seven_segment_text_scan_driver_top_macros.svh
// Assertion macros for the seven-segment text scan driver.
// Expect clk_i and rst_ni in the scope of use; no other dependencies.
`ifndef SEVEN_SEGMENT_TEXT_SCAN_DRIVER_TOP_MACROS_SVH
`define SEVEN_SEGMENT_TEXT_SCAN_DRIVER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SSTD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define SSTD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SSTD_ASSERT_IMP(label, ante, cons, msg)
`define SSTD_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

>>> rtl/core/sstd_pkg.sv
// Package for the seven-segment text scan driver: sizes, item types,
// mode codes and the character-to-segment lookup. No dependencies.
package sstd_pkg;

  localparam int DIGIT_COUNT = 4;
  localparam int GROUP_COUNT = 4;

  localparam int WP_W      = $clog2(DIGIT_COUNT + 1);
  localparam int DIG_IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  // scan index holds 0..7 for any group count up to eight, and the reset value two
  localparam int SCAN_W    = 3;
  localparam logic [SCAN_W-1:0] SCAN_RESET = 3'd2;

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_CHAR  = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  localparam logic [7:0] CHAR_DOT  = 8'h2E;
  localparam logic [7:0] CHAR_DASH = 8'h2D;
  localparam int         DOT_BIT   = 4;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic serial_bit;
    logic latch_pulse;
    logic last;
  } out_item_t;

  typedef struct packed {
    logic       start_text;
    logic       put_char;
    logic       tick;
    logic [7:0] char_code;
  } text_cmd_t;

  typedef struct packed {
    logic        two;   // second frame follows the blank one
    logic [15:0] word;
  } frame_t;

  localparam logic [7:0] SEG_ROM [0:37] = '{
    8'h00, 8'hE7, 8'h21, 8'hCB, 8'h6B, 8'h2D, 8'h6E, 8'hEE, 8'h23, 8'hEF,
    8'h6F, 8'hAF, 8'hEC, 8'hC6, 8'hE9, 8'hCE, 8'h8E, 8'hE6, 8'hAD, 8'h20,
    8'hE1, 8'hAE, 8'hC4, 8'hA7, 8'hA8, 8'hE8, 8'h8F, 8'h2F, 8'h88, 8'h6E,
    8'hCC, 8'hE0, 8'hE5, 8'hED, 8'hAD, 8'h6D, 8'hCB, 8'h08
  };

  function automatic logic [5:0] symbol_of(input logic [7:0] c);
    logic [7:0] s;
    s = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      s = c - 8'h30 + 8'd1;
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      s = c - 8'h41 + 8'd11;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s = c - 8'h61 + 8'd11;
    end else if (c == CHAR_DASH) begin
      s = 8'd37;
    end
    return s[5:0];
  endfunction

  function automatic logic [7:0] seg_of_char(input logic [7:0] c);
    return SEG_ROM[symbol_of(c)];
  endfunction

endpackage

>>> rtl/core/sstd_text.sv
// Text state of the scan driver: digit store, write position, dot flag
// and scan index; builds the digit frame for a tick. Uses sstd_pkg.
module sstd_text (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sstd_pkg::text_cmd_t cmd_i,
  output sstd_pkg::frame_t    frame_o
);
  import sstd_pkg::*;

  logic [7:0]           digit_q [DIGIT_COUNT];
  logic [7:0]           digit_d [DIGIT_COUNT];
  logic [WP_W-1:0]      wp_q, wp_d;
  logic                 after_dot_q, after_dot_d;
  logic [SCAN_W-1:0]    scan_q, scan_d;
  logic [SCAN_W:0]      scan_inc;
  logic [WP_W-1:0]      wp_prev;
  logic                 full;
  logic                 is_dot;
  logic                 dot_set;
  logic                 wr_digit;
  logic [7:0]           seg;

  assign full     = (wp_q == WP_W'(DIGIT_COUNT));
  assign is_dot   = (cmd_i.char_code == CHAR_DOT);
  assign wp_prev  = wp_q - WP_W'(1);
  assign seg      = seg_of_char(cmd_i.char_code);
  assign dot_set  = cmd_i.put_char && !full && is_dot && !after_dot_q && (wp_q != '0);
  assign wr_digit = cmd_i.put_char && !full && !(is_dot && !after_dot_q);
  assign scan_inc = {1'b0, scan_q} + (SCAN_W+1)'(1);

  always_comb begin
    wp_d        = wp_q;
    after_dot_d = after_dot_q;
    scan_d      = scan_q;
    for (int k = 0; k < DIGIT_COUNT; k++) begin
      digit_d[k] = digit_q[k];
      if (wr_digit && wp_q[DIG_IDX_W-1:0] == DIG_IDX_W'(k)) begin
        digit_d[k] = seg;
      end
      if (dot_set && wp_prev[DIG_IDX_W-1:0] == DIG_IDX_W'(k)) begin
        digit_d[k][DOT_BIT] = 1'b1;
      end
    end
    if (cmd_i.start_text) begin
      wp_d        = '0;
      after_dot_d = 1'b0;
    end
    if (dot_set) begin
      after_dot_d = 1'b1;
    end
    if (wr_digit) begin
      wp_d        = wp_q + WP_W'(1);
      after_dot_d = 1'b0;
    end
    if (cmd_i.tick) begin
      scan_d = (scan_inc >= (SCAN_W+1)'(GROUP_COUNT)) ? '0 : scan_inc[SCAN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIGIT_COUNT; k++) begin
        digit_q[k] <= '0;
      end
      wp_q        <= '0;
      after_dot_q <= 1'b0;
      scan_q      <= SCAN_RESET;
    end else begin
      digit_q     <= digit_d;
      wp_q        <= wp_d;
      after_dot_q <= after_dot_d;
      scan_q      <= scan_d;
    end
  end

  // Digit byte on the high half, one-hot digit select on the low half.
  assign frame_o.two  = ({1'b0, scan_q} < (SCAN_W+1)'(DIGIT_COUNT));
  assign frame_o.word = {digit_q[scan_q[DIG_IDX_W-1:0]], 8'h80 >> scan_q};

endmodule

>>> rtl/core/sstd_ser.sv
// Output serializer: shifts a blank frame and an optional digit frame
// out one bit per beat, LSB first. Uses sstd_pkg.
module sstd_ser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  sstd_pkg::frame_t    frame_i,
  output logic                can_load_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sstd_pkg::out_item_t out_item_o
);
  import sstd_pkg::*;

  logic        valid_q, valid_d;
  logic [31:0] shift_q, shift_d;
  logic [4:0]  idx_q, idx_d;
  logic        two_q, two_d;
  logic        is_last;
  logic        take;

  assign is_last    = (idx_q == {two_q, 4'hF});
  assign take       = valid_q && out_ready_i;
  assign can_load_o = !valid_q || (take && is_last);

  always_comb begin
    valid_d = valid_q;
    shift_d = shift_q;
    idx_d   = idx_q;
    two_d   = two_q;
    if (take) begin
      shift_d = {1'b0, shift_q[31:1]};
      idx_d   = idx_q + 5'd1;
      if (is_last) begin
        valid_d = 1'b0;
      end
    end
    if (load_i) begin
      valid_d = 1'b1;
      shift_d = {frame_i.word, 16'h0000};
      idx_d   = '0;
      two_d   = frame_i.two;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
      two_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
      two_q   <= two_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
  end

  assign out_valid_o            = valid_q;
  assign out_item_o.serial_bit  = shift_q[0];
  assign out_item_o.latch_pulse = &idx_q[3:0];
  assign out_item_o.last        = is_last;

endmodule

>>> rtl/core/seven_segment_text_scan_driver_top.sv
// Seven-segment text scan driver, top level.
// Depends on sstd_pkg, sstd_text, sstd_ser and the assertion macro header.
//
// Input channel (in_valid_i/in_ready_o, in_item_i): mode 0 starts a new
// text, mode 1 writes one character (dots merge into the previous digit),
// mode 2 is a refresh tick, mode 3 is dropped. Only ticks produce beats.
// Output channel (out_valid_o/out_ready_i, out_item_o): one beat per
// serial bit, frame LSB first; latch_pulse marks the sixteenth bit of each
// frame and last marks the final beat of a tick.
// Each tick gives 16 beats (blank frame) or 32 beats (blank frame, then
// digit frame) when the scan index points at a digit.
// Every item lands in a one-entry input register; text items update the
// digit store on the next cycle and never stall. A tick leaves that
// register the cycle after it arrives if the serializer is free, and its
// first beat shows once the serializer has loaded it. The serializer
// emits one bit per cycle while the receiver is ready, and a waiting
// tick loads as the last beat of the run before it is taken, so runs
// follow with no gap. While the receiver stalls, the current beat holds
// and one further item waits in the input register; text items behind a
// held tick wait too. Reset clears the digit store, write position and
// dot flag, sets the scan index to two and empties both registers.
module seven_segment_text_scan_driver_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sstd_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sstd_pkg::out_item_t out_item_o
);
  import sstd_pkg::*;

  `include "seven_segment_text_scan_driver_top_macros.svh"

  logic      in_valid_q, in_valid_d;
  in_item_t  in_item_q;
  logic      can_load;
  logic      advance;
  logic      held_tick;
  logic      load;
  text_cmd_t cmd;
  frame_t    frame;

  assign held_tick  = in_valid_q && (in_item_q.mode == MODE_TICK);
  assign advance    = in_valid_q && (!held_tick || can_load);
  assign load       = held_tick && can_load;
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (advance) begin
      in_valid_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Payload holds until the next accepted beat.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_item_i;
    end
  end

  assign cmd.start_text = advance && (in_item_q.mode == MODE_START);
  assign cmd.put_char   = advance && (in_item_q.mode == MODE_CHAR);
  assign cmd.tick       = load;
  assign cmd.char_code  = in_item_q.char_code;

  sstd_text u_text (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .frame_o (frame)
  );

  sstd_ser u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .frame_i     (frame),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  `SSTD_ASSERT_IMP(a_last_on_latch, out_valid_o && out_item_o.last, out_item_o.latch_pulse, "last beat off a frame end")
  `SSTD_ASSERT_IMP(a_load_when_free, load, !out_valid_o || (out_ready_i && out_item_o.last), "serializer loaded while busy")
  `SSTD_ASSERT_NXT(a_run_continues, out_valid_o && out_ready_i && !out_item_o.last, out_valid_o, "tick run cut short")
  `SSTD_ASSERT_IMP(a_tick_holds, held_tick && !can_load, !in_ready_o, "input taken over a held tick")

endmodule

>>> sim/tb_top.sv
// Testbench for the seven-segment text scan driver: drives text, dot and tick beats
// and predicts the serial bit stream with its own digit store and scan counter.
// Depends on sstd_pkg and the seven_segment_text_scan_driver_top RTL.
module tb_top;

  localparam int unsigned DIGITS         = sstd_pkg::DIGIT_COUNT;
  localparam int unsigned GROUPS         = sstd_pkg::GROUP_COUNT;
  localparam logic [1:0]  MODE_UNUSED    = 2'd3;
  localparam int unsigned ITEM_TARGET    = 470;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES   = 64;

  // segment byte for each symbol index: blank, digits, letters, dash
  localparam bit [7:0] GLYPH_ROM [38] = '{
    8'h00, 8'hE7, 8'h21, 8'hCB, 8'h6B, 8'h2D, 8'h6E, 8'hEE, 8'h23, 8'hEF,
    8'h6F, 8'hAF, 8'hEC, 8'hC6, 8'hE9, 8'hCE, 8'h8E, 8'hE6, 8'hAD, 8'h20,
    8'hE1, 8'hAE, 8'hC4, 8'hA7, 8'hA8, 8'hE8, 8'h8F, 8'h2F, 8'h88, 8'h6E,
    8'hCC, 8'hE0, 8'hE5, 8'hED, 8'hAD, 8'h6D, 8'hCB, 8'h08
  };

  class beat_scoreboard;
    sstd_pkg::out_item_t pending_beats[$];
    bit [7:0]    digits [DIGITS];
    int unsigned wr_pos;
    bit          dot_seen;
    int unsigned scan_pos;
    int unsigned mismatches;
    int unsigned beats_checked;
    int unsigned starts, chars, ticks, others;

    function new();
      foreach (digits[k]) digits[k] = 8'h00;
      wr_pos     = 0;
      dot_seen   = 1'b0;
      scan_pos   = 2;
      mismatches = 0;
      beats_checked = 0;
      starts = 0;
      chars  = 0;
      ticks  = 0;
      others = 0;
    endfunction

    function void push_frame(bit [15:0] word, bit final_frame);
      sstd_pkg::out_item_t b;
      for (int i = 0; i < 16; i++) begin
        b.serial_bit  = word[i];
        b.latch_pulse = (i == 15);
        b.last        = final_frame && (i == 15);
        pending_beats.push_back(b);
      end
    endfunction

    function void note_item(sstd_pkg::in_item_t it);
      int unsigned sym;
      bit [7:0]    c;
      c = it.char_code;
      case (it.mode)
        sstd_pkg::MODE_START: begin
          starts++;
          wr_pos   = 0;
          dot_seen = 1'b0;
        end
        sstd_pkg::MODE_CHAR: begin
          chars++;
          if (wr_pos < DIGITS) begin
            if (c == sstd_pkg::CHAR_DOT && !dot_seen) begin
              // merge into the previous digit; nothing to merge into at position zero
              if (wr_pos > 0) begin
                digits[wr_pos-1][sstd_pkg::DOT_BIT] = 1'b1;
                dot_seen = 1'b1;
              end
            end else begin
              sym = 0;
              if (c >= "0" && c <= "9") sym = c - "0" + 1;
              else if (c >= "A" && c <= "Z") sym = c - "A" + 11;
              else if (c >= "a" && c <= "z") sym = c - "a" + 11;
              else if (c == sstd_pkg::CHAR_DASH) sym = 37;
              digits[wr_pos] = GLYPH_ROM[sym];
              wr_pos++;
              dot_seen = 1'b0;
            end
          end
        end
        sstd_pkg::MODE_TICK: begin
          ticks++;
          push_frame(16'h0000, scan_pos >= DIGITS);
          if (scan_pos < DIGITS) begin
            push_frame({digits[scan_pos], 8'h80 >> scan_pos}, 1'b1);
          end
          scan_pos = (scan_pos + 1 >= GROUPS) ? 0 : scan_pos + 1;
        end
        default: others++;
      endcase
    endfunction

    function void compare_field(string name, bit want, logic got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: beat %0d %s expected %0b actual %0b",
                 $time, beats_checked, name, want, got);
      end
    endfunction

    function void check_beat(sstd_pkg::out_item_t got);
      sstd_pkg::out_item_t want;
      beats_checked++;
      if (pending_beats.size() == 0) begin
        mismatches++;
        $display("%0t: beat %0d expected none actual %b", $time, beats_checked, got);
        return;
      end
      want = pending_beats.pop_front();
      compare_field("serial_bit", want.serial_bit, got.serial_bit);
      compare_field("latch_pulse", want.latch_pulse, got.latch_pulse);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  sstd_pkg::in_item_t  in_item_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  sstd_pkg::out_item_t out_item_o;

  beat_scoreboard sb = new();

  bit          rx_hold_req = 1'b0;
  bit          tx_burst = 1'b0;
  int unsigned sent_useful = 0;

  seven_segment_text_scan_driver_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Offer one beat, hold it until accepted, then maybe leave a gap.
  task automatic send_item(input logic [1:0] mode, input logic [7:0] code);
    sstd_pkg::in_item_t it;
    int unsigned        gap;
    int unsigned        r;
    it.mode      = mode;
    it.char_code = code;
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_item(it);
    if (mode != MODE_UNUSED) sent_useful++;
    r = $urandom_range(0, 19);
    if (tx_burst || r < 11) gap = 0;
    else if (r < 18) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every predicted beat has come out.
  task automatic drain_beats();
    in_valid_i <= 1'b0;
    while (sb.pending_beats.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_char();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0, 1:    c = 8'("0" + $urandom_range(0, 9));
      2:       c = 8'("A" + $urandom_range(0, 25));
      3:       c = 8'("a" + $urandom_range(0, 25));
      4:       c = sstd_pkg::CHAR_DASH;
      5, 6:    c = sstd_pkg::CHAR_DOT;
      7:       c = 8'($urandom_range(128, 255));
      default: c = 8'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  function automatic logic [7:0] any_code();
    return 8'($urandom_range(0, 255));
  endfunction

  // Receiver: check each accepted beat, then pick the next ready value.
  initial begin : beat_sink
    int unsigned hold_left;
    int unsigned gap_left;
    int unsigned run_left;
    bit          next_ready;
    hold_left = 0;
    gap_left  = 0;
    run_left  = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_beat(out_item_o);
      if (rx_hold_req) begin
        hold_left   = RX_HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        next_ready = 1'b0;
      end else if (run_left > 0) begin
        run_left--;
        next_ready = 1'b1;
      end else begin
        run_left   = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150)
                                                 : $urandom_range(1, 12);
        gap_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                 : $urandom_range(0, 3);
        next_ready = 1'b1;
      end
      out_ready_i <= next_ready;
    end
  end

  initial begin : watchdog
    #20000000;
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    bit          hold_done;
    bit          drain_done;
    int unsigned kind;
    int unsigned n;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: empty store, unused mode, dot cases, full display, blank codes
    send_item(sstd_pkg::MODE_TICK, any_code());
    send_item(MODE_UNUSED, "5");
    send_item(sstd_pkg::MODE_START, 8'hFF);
    send_item(sstd_pkg::MODE_CHAR, sstd_pkg::CHAR_DOT);
    send_item(sstd_pkg::MODE_CHAR, "0");
    send_item(sstd_pkg::MODE_CHAR, sstd_pkg::CHAR_DOT);
    send_item(sstd_pkg::MODE_CHAR, sstd_pkg::CHAR_DOT);
    send_item(sstd_pkg::MODE_CHAR, "z");
    send_item(sstd_pkg::MODE_CHAR, sstd_pkg::CHAR_DASH);
    send_item(sstd_pkg::MODE_CHAR, "A");
    send_item(sstd_pkg::MODE_CHAR, sstd_pkg::CHAR_DOT);
    repeat (4) send_item(sstd_pkg::MODE_TICK, any_code());
    send_item(sstd_pkg::MODE_START, 8'h00);
    send_item(sstd_pkg::MODE_CHAR, "9");
    send_item(sstd_pkg::MODE_CHAR, "Z");
    send_item(sstd_pkg::MODE_CHAR, 8'h80);
    send_item(sstd_pkg::MODE_CHAR, 8'hFF);
    send_item(sstd_pkg::MODE_START, any_code());
    send_item(sstd_pkg::MODE_CHAR, 8'h00);
    send_item(sstd_pkg::MODE_CHAR, "a");
    repeat (2) send_item(sstd_pkg::MODE_TICK, any_code());
    drain_beats();

    while (sent_useful < ITEM_TARGET) begin
      tx_burst = ($urandom_range(0, 4) == 0);
      if (!hold_done && sent_useful > 150) begin
        // stall the receiver and keep ticks coming so the input backs up
        hold_done   = 1'b1;
        rx_hold_req = 1'b1;
        tx_burst    = 1'b1;
        repeat (4) send_item(sstd_pkg::MODE_TICK, any_code());
      end
      if (!drain_done && sent_useful > 300) begin
        drain_done = 1'b1;
        drain_beats();
      end
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        send_item(sstd_pkg::MODE_START, any_code());
        n = $urandom_range(0, 6);
        repeat (n) send_item(sstd_pkg::MODE_CHAR, pick_char());
        n = $urandom_range(1, 4);
        repeat (n) send_item(sstd_pkg::MODE_TICK, any_code());
      end else if (kind == 7) begin
        n = $urandom_range(1, 3);
        repeat (n) send_item(2'($urandom_range(0, 3)), any_code());
      end else if (kind == 8) begin
        n = $urandom_range(1, 4);
        repeat (n) send_item(sstd_pkg::MODE_CHAR, pick_char());
      end else begin
        n = $urandom_range(1, 3);
        repeat (n) send_item(sstd_pkg::MODE_TICK, any_code());
      end
    end

    drain_beats();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Run covered %0d begin, %0d character, %0d tick and %0d unused-mode items,",
             sb.starts, sb.chars, sb.ticks, sb.others);
    $display("with %0d serial beats checked and one %0d-cycle receiver stall.",
             sb.beats_checked, RX_HOLD_CYCLES);
    if (sb.mismatches == 0 && sb.pending_beats.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> seven_segment_text_scan_driver_top.f
+incdir+rtl/core
rtl/core/sstd_pkg.sv
rtl/core/sstd_text.sv
rtl/core/sstd_ser.sv
rtl/core/seven_segment_text_scan_driver_top.sv
sim/tb_top.sv
